>>> rtl/core/psgd_pkg.sv
// Shared types and constants for the sound generator register write decoder.
`timescale 1ns / 1ps

package psgd_pkg;

    localparam int CHANNELS = 4;
    localparam int CH_W = $clog2(CHANNELS);
    localparam int TONE_W = 10;
    localparam int VOL_W = 4;
    localparam int BYTE_W = 8;

    localparam logic [CH_W-1:0] CH_NOISE = CH_W'(3);
    localparam logic [CH_W-1:0] CH_LINKED = CH_W'(2);
    localparam logic [1:0] RATE_FOLLOW = 2'd3;
    localparam logic [VOL_W-1:0] VOL_RESET = 4'hF;

    typedef logic [BYTE_W-1:0] psgd_byte_t;

    typedef struct packed {
        logic volume_event;
        logic tone_event;
        logic noise_tone_event;
        logic noise_type_event;
        logic mode_event;
        logic [CH_W-1:0] event_channel;
        logic [TONE_W-1:0] channel_tone;
        logic [VOL_W-1:0] channel_volume;
        logic noise_kind;
        logic noise_follows_ch2;
    } psgd_result_t;

    typedef struct packed {
        logic advance;
        psgd_byte_t write_byte;
    } psgd_issue_t;

endpackage

>>> rtl/core/psgd_stream_if.sv
// Valid/ready channel interface that carries one payload beat.
`timescale 1ns / 1ps

interface psgd_stream_if #(
    parameter type payload_t = logic
);
    logic valid;
    logic ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/psgd_in_stage.sv
// Input register that holds one written byte until the decoder takes it.
`timescale 1ns / 1ps

module psgd_in_stage (
    input  logic clk,
    input  logic rst_n,
    psgd_stream_if.sink wr,
    input  logic take,
    output psgd_pkg::psgd_issue_t issue
);

    logic valid_reg;
    psgd_pkg::psgd_byte_t byte_reg;
    logic load;

    assign wr.ready = !valid_reg || take;
    assign load = wr.valid && wr.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr.ready)
        begin
            valid_reg <= wr.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= wr.payload;
        end
    end

    assign issue.advance = valid_reg && take;
    assign issue.write_byte = byte_reg;

endmodule

>>> rtl/core/psgd_decoder.sv
// Channel state registers and the decode of one byte into a state update and result.
`timescale 1ns / 1ps

module psgd_decoder (
    input  logic clk,
    input  logic rst_n,
    input  psgd_pkg::psgd_issue_t issue,
    output psgd_pkg::psgd_result_t result
);

    logic [psgd_pkg::TONE_W-1:0] tone_reg [psgd_pkg::CHANNELS];
    logic [psgd_pkg::TONE_W-1:0] tone_next [psgd_pkg::CHANNELS];
    logic [psgd_pkg::VOL_W-1:0] vol_reg [psgd_pkg::CHANNELS];
    logic [psgd_pkg::VOL_W-1:0] vol_next [psgd_pkg::CHANNELS];
    logic noise_type_reg, noise_type_next;
    logic noise_mode_reg, noise_mode_next;
    logic [psgd_pkg::CH_W-1:0] chan_reg, chan_next;
    logic pending_reg, pending_next;
    logic [3:0] low_nibble_reg, low_nibble_next;
    logic vol_latch_reg, vol_latch_next;

    always_comb
    begin
        logic [7:0] b;
        logic do_noise;
        logic do_volume;
        logic new_mode;
        b = issue.write_byte;
        do_noise = 1'b0;
        do_volume = 1'b0;
        tone_next = tone_reg;
        vol_next = vol_reg;
        noise_type_next = noise_type_reg;
        noise_mode_next = noise_mode_reg;
        chan_next = chan_reg;
        pending_next = pending_reg;
        low_nibble_next = low_nibble_reg;
        vol_latch_next = 1'b0;
        result = '0;

        if (!b[7])
        begin
            if (pending_reg)
            begin
                if (noise_mode_reg && chan_reg == psgd_pkg::CH_LINKED)
                begin
                    chan_next = psgd_pkg::CH_NOISE;
                end
                tone_next[chan_next] = {b[5:0], low_nibble_reg};
                if (chan_next == psgd_pkg::CH_NOISE)
                begin
                    result.noise_tone_event = 1'b1;
                end
                else
                begin
                    result.tone_event = 1'b1;
                end
                pending_next = 1'b0;
                low_nibble_next = 4'd0;
            end
            else if (vol_latch_reg)
            begin
                do_volume = 1'b1;
            end
            else
            begin
                do_noise = 1'b1;
            end
        end
        else
        begin
            chan_next = b[6:5];
            if (!b[4])
            begin
                if (chan_next != psgd_pkg::CH_NOISE)
                begin
                    if (!pending_reg)
                    begin
                        pending_next = 1'b1;
                        low_nibble_next = b[3:0];
                    end
                end
                else
                begin
                    do_noise = 1'b1;
                end
            end
            else
            begin
                vol_latch_next = 1'b1;
                do_volume = 1'b1;
            end
        end

        if (do_volume)
        begin
            vol_next[chan_next] = b[3:0];
            result.volume_event = 1'b1;
        end

        new_mode = (b[1:0] == psgd_pkg::RATE_FOLLOW);
        if (do_noise)
        begin
            noise_type_next = b[2];
            noise_mode_next = new_mode;
            result.mode_event = (new_mode != noise_mode_reg);
            if (!new_mode)
            begin
                tone_next[chan_next] = {{(psgd_pkg::TONE_W-2){1'b0}}, b[1:0]};
                result.noise_tone_event = 1'b1;
            end
            result.noise_type_event = 1'b1;
        end

        result.event_channel = chan_next;
        result.channel_tone = tone_next[chan_next];
        result.channel_volume = vol_next[chan_next];
        result.noise_kind = noise_type_next;
        result.noise_follows_ch2 = noise_mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < psgd_pkg::CHANNELS; i++)
            begin
                tone_reg[i] <= '0;
                vol_reg[i] <= psgd_pkg::VOL_RESET;
            end
            noise_type_reg <= 1'b0;
            noise_mode_reg <= 1'b0;
            chan_reg <= '0;
            pending_reg <= 1'b0;
            low_nibble_reg <= 4'd0;
            vol_latch_reg <= 1'b0;
        end
        else if (issue.advance)
        begin
            tone_reg <= tone_next;
            vol_reg <= vol_next;
            noise_type_reg <= noise_type_next;
            noise_mode_reg <= noise_mode_next;
            chan_reg <= chan_next;
            pending_reg <= pending_next;
            low_nibble_reg <= low_nibble_next;
            vol_latch_reg <= vol_latch_next;
        end
    end

endmodule

>>> rtl/core/psgd_out_stage.sv
// Result register that holds one decoded beat until the sink takes it.
`timescale 1ns / 1ps

module psgd_out_stage (
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  psgd_pkg::psgd_result_t result,
    output logic can_load,
    psgd_stream_if.source res
);

    logic valid_reg;
    psgd_pkg::psgd_result_t result_reg;

    assign can_load = !valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && load)
        begin
            result_reg <= result;
        end
    end

    assign res.valid = valid_reg;
    assign res.payload = result_reg;

endmodule

>>> rtl/core/psgd_register_write_decoder_core.sv
// Top level of the sound generator register write decoder.
`timescale 1ns / 1ps
// An accepted byte is held in the input register, then decoded into the result register.
// Throughput: one byte per cycle; the input register and result register both advance
// together whenever the result register is empty or being taken.
// Reset: rst_n clears all channel state (tones 0, volumes 15) and empties both registers.

module psg_register_write_decoder_core (
    input  logic clk,
    input  logic rst_n,
    psgd_stream_if.sink wr,
    psgd_stream_if.source res
);

    psgd_pkg::psgd_issue_t issue;
    psgd_pkg::psgd_result_t result;
    logic can_load;

    psgd_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .take  (can_load),
        .issue (issue)
    );

    psgd_decoder u_decoder (
        .clk    (clk),
        .rst_n  (rst_n),
        .issue  (issue),
        .result (result)
    );

    psgd_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (issue.advance),
        .result   (result),
        .can_load (can_load),
        .res      (res)
    );

    a_single_tone_event: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !(res.payload.tone_event && res.payload.noise_tone_event))
        else $error("Tone and noise tone events fired on one beat.");

    a_mode_needs_noise_write: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.payload.mode_event) |-> res.payload.noise_type_event)
        else $error("Mode change reported without a noise control write.");

    a_noise_write_sets_tone: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.payload.noise_type_event && !res.payload.noise_follows_ch2)
            |-> res.payload.noise_tone_event)
        else $error("Noise control write with free-running rate did not set a tone.");

    a_volume_excludes_tone: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.payload.volume_event)
            |-> !(res.payload.tone_event || res.payload.noise_type_event))
        else $error("Volume beat also reported a tone or noise update.");

endmodule
